[design/msh_pkg.sv]
// msh_pkg: shared types, constants and helpers for the string hash block
// no dependencies; compiled first

package msh_pkg;

   localparam int BYTE_W = 8;
   localparam int HASH_W = 30;
   localparam int WORD_W = 32;
   localparam int TAIL_W = 24;

   localparam logic [WORD_W-1:0] C1      = 32'hcc9e2d51;
   localparam logic [WORD_W-1:0] C2      = 32'h1b873593;
   localparam logic [WORD_W-1:0] MIX_ADD = 32'he6546b64;
   localparam logic [WORD_W-1:0] F1      = 32'h85ebca6b;
   localparam logic [WORD_W-1:0] F2      = 32'hc2b2ae35;
   localparam logic [WORD_W-1:0] FOLD    = 32'h3fffffff;

   // one queued command from the packer to the mixer
   typedef struct packed {
      logic              blk;     // word is a full four-byte block
      logic              fin;     // string ends, finalize after any mix
      logic              tail;    // word is a zero-filled partial tail
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] length;
      logic [WORD_W-1:0] seed;    // seed in force when the string started
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MIX,
      ST_AV1,
      ST_AV2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic pop;
      logic mul1;
      logic mul2;
      logic mix;
      logic av1;
      logic av2;
      logic emit;
   } back_ctl_type;

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                input int unsigned n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

endpackage

[design/msh_req_if.sv]
// msh_req_if: request channel carrying string bytes
// depends on msh_pkg

interface msh_req_if
   import msh_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last;
   logic              empty_req;

   modport source (output valid, output data_byte, output last, output empty_req,
                   input ready);
   modport sink   (input valid, input data_byte, input last, input empty_req,
                   output ready);
endinterface

[design/msh_rsp_if.sv]
// msh_rsp_if: response channel carrying the finished hash
// depends on msh_pkg

interface msh_rsp_if
   import msh_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] hash;

   modport source (output valid, output hash, input ready);
   modport sink   (input valid, input hash, output ready);
endinterface

[design/msh_front.sv]
// msh_front: takes request bytes, packs them into words, queues mix/finish commands
// depends on msh_pkg and msh_req_if

module msh_front
   import msh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [WORD_W-1:0] seed,
   msh_req_if.sink           req_ch,
   input  logic              q_ready,
   output logic              q_push,
   output cmd_type           q_cmd
);

   logic [TAIL_W-1:0] pending_ff, pending_in;
   logic [1:0]        phase_ff, phase_in;
   logic [WORD_W-1:0] length_ff, length_in;
   logic              in_str_ff, in_str_in;
   logic [WORD_W-1:0] str_seed_ff, str_seed_in;

   logic              accept;
   logic              has_byte;
   logic              blk;
   logic [TAIL_W-1:0] byte_shifted;

   assign req_ch.ready = q_ready;
   assign accept       = req_ch.valid && q_ready;
   assign has_byte     = !req_ch.empty_req;
   assign blk          = has_byte && (phase_ff == 2'd3);
   assign byte_shifted = {16'h0, req_ch.data_byte} << {phase_ff, 3'b000};

   always_comb begin
      if (blk) begin
         pending_in = '0;
         phase_in   = 2'd0;
      end else if (has_byte) begin
         pending_in = pending_ff | byte_shifted;
         phase_in   = phase_ff + 2'd1;
      end else begin
         pending_in = pending_ff;
         phase_in   = phase_ff;
      end
      length_in = length_ff + WORD_W'(has_byte);
      // seed is captured by the first byte of a string
      in_str_in   = in_str_ff || has_byte;
      str_seed_in = in_str_ff ? str_seed_ff : seed;
   end

   always_comb begin
      q_push        = accept && (blk || req_ch.last);
      q_cmd.blk     = blk;
      q_cmd.fin     = req_ch.last;
      q_cmd.tail    = (phase_in != 2'd0);
      q_cmd.word    = blk ? {req_ch.data_byte, pending_ff} : {8'h0, pending_in};
      q_cmd.length  = length_in;
      q_cmd.seed    = str_seed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         phase_ff    <= '0;
         length_ff   <= '0;
         in_str_ff   <= 1'b0;
         str_seed_ff <= '0;
      end else if (accept) begin
         if (req_ch.last) begin
            pending_ff <= '0;
            phase_ff   <= '0;
            length_ff  <= '0;
            in_str_ff  <= 1'b0;
         end else begin
            pending_ff  <= pending_in;
            phase_ff    <= phase_in;
            length_ff   <= length_in;
            in_str_ff   <= in_str_in;
            str_seed_ff <= str_seed_in;
         end
      end
   end

endmodule

[design/msh_queue.sv]
// msh_queue: small command queue between packer and mixer
// depends on msh_pkg

module msh_queue
   import msh_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_in;
         if (do_pop)  rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

[design/msh_back.sv]
// msh_back: block mixer and finalizer sequencer with output register
// depends on msh_pkg and msh_rsp_if

module msh_back
   import msh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   msh_rsp_if.source         rsp_ch
);

   state_type         state_ff, state_in;
   back_ctl_type      ctl;
   cmd_type           cmd_ff;
   logic [WORD_W-1:0] hash_ff;
   logic [WORD_W-1:0] d_ff;
   logic              fresh_ff;
   logic              rsp_valid_ff;
   logic [HASH_W-1:0] rsp_hash_ff;

   logic              out_free;
   logic              q_needs_mix;
   logic [WORD_W-1:0] mix_rot;
   logic [WORD_W-1:0] av_pre;
   logic [WORD_W-1:0] av_out;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign q_needs_mix = q_cmd.blk || (q_cmd.fin && q_cmd.tail);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.hash  = rsp_hash_ff;
   assign q_pop        = ctl.pop;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = q_needs_mix ? ST_MUL1 : ST_AV1;
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MIX;
         ST_MIX:  state_in = cmd_ff.fin ? ST_AV1 : ST_IDLE;
         ST_AV1:  state_in = ST_AV2;
         ST_AV2:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE: ctl.pop  = q_valid;
         ST_MUL1: ctl.mul1 = 1'b1;
         ST_MUL2: ctl.mul2 = 1'b1;
         ST_MIX:  ctl.mix  = 1'b1;
         ST_AV1:  ctl.av1  = 1'b1;
         ST_AV2:  ctl.av2  = 1'b1;
         ST_OUT:  ctl.emit = out_free;
         default: ctl      = '0;
      endcase
   end

   assign mix_rot = rotl32(hash_ff ^ d_ff, 13);
   assign av_pre  = hash_ff ^ cmd_ff.length;
   assign av_out  = d_ff ^ (d_ff >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctl.mix) fresh_ff <= 1'b0;
         else if (ctl.emit) fresh_ff <= 1'b1;
         if (ctl.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pop) begin
         cmd_ff <= q_cmd;
         if (fresh_ff) hash_ff <= q_cmd.seed;
      end
      if (ctl.mul1) d_ff <= cmd_ff.word * C1;
      if (ctl.mul2) d_ff <= rotl32(d_ff, 15) * C2;
      if (ctl.mix)  hash_ff <= mix_rot * 32'd5 + MIX_ADD;
      if (ctl.av1)  d_ff <= (av_pre ^ (av_pre >> 16)) * F1;
      if (ctl.av2)  d_ff <= (d_ff ^ (d_ff >> 13)) * F2;
      if (ctl.emit) rsp_hash_ff <= HASH_W'(av_out & FOLD);
   end

endmodule

[design/murmur_string_hash_top.sv]
// murmur_string_hash_top: byte-serial 32-bit murmur-style string hash, 30-bit result
// a last request's command passes the queue, MUL1, MUL2 and MIX if a word is left,
// then AV1, AV2 and OUT; bytes enter one per cycle while the queue has room and each
// word takes IDLE, MUL1, MUL2 and MIX, so long strings sustain about one byte per cycle
// reset: synchronous, active high; seed clears to zero, queue and sequencer empty
// depends on msh_pkg, msh_req_if, msh_rsp_if, msh_front, msh_queue, msh_back

module murmur_string_hash_top
   import msh_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic              clock,
   input  logic              reset,
   msh_req_if.sink           req_ch,
   msh_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data
);

   // seed register, captured by the packer whenever a new string starts
   logic [WORD_W-1:0] seed_ff;

   // command path between packer and mixer
   logic    q_push;
   logic    q_ready;
   cmd_type q_push_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   // front: packs bytes little-endian, counts length, emits block and finish commands
   msh_front u_front (
      .clock   (clock),
      .reset   (reset),
      .seed    (seed_ff),
      .req_ch  (req_ch),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_cmd   (q_push_cmd)
   );

   // queue: lets the packer keep taking bytes while the mixer is busy
   msh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (q_pop_cmd)
   );

   // back: multi-cycle block mix, length fold-in, avalanche, output register
   msh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_pop_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // packer never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> q_ready)
      else $error("command pushed while queue full");

   // mixer only pops when a command is waiting
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("command popped from empty queue");

   // a rising response valid never directly follows a pop of the mixer
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_ch.valid) |-> !$past(q_pop))
      else $error("response raised right after a pop");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for murmur_string_hash_top, random strings under idle and stall
// depends on msh_pkg, msh_req_if, msh_rsp_if and the block itself

module tb_top
   import msh_pkg::*;
();

   // bit-exact string hash predictor with its queue of awaited hashes
   class string_hash_model;
      bit [WORD_W-1:0] seed;
      bit [WORD_W-1:0] running_hash;
      bit [TAIL_W-1:0] tail_bytes;
      bit [1:0]        tail_count;
      bit [WORD_W-1:0] byte_count;
      bit              in_string;
      bit [HASH_W-1:0] expected_hashes[$];
      int              mismatch_count;

      function new();
         seed = '0;
         running_hash = '0;
         tail_bytes = '0;
         tail_count = '0;
         byte_count = '0;
         in_string = 1'b0;
         mismatch_count = 0;
      endfunction

      function bit [WORD_W-1:0] rotate_left(bit [WORD_W-1:0] x, int unsigned n);
         return (x << n) | (x >> (WORD_W - n));
      endfunction

      function bit [WORD_W-1:0] mix_word(bit [WORD_W-1:0] h, bit [WORD_W-1:0] d);
         bit [WORD_W-1:0] k;
         k = d * C1;
         k = rotate_left(k, 15);
         k = k * C2;
         h = h ^ k;
         h = rotate_left(h, 13);
         h = h * 32'd5 + MIX_ADD;
         return h;
      endfunction

      function bit [WORD_W-1:0] avalanche(bit [WORD_W-1:0] h);
         h = h ^ (h >> 16);
         h = h * F1;
         h = h ^ (h >> 13);
         h = h * F2;
         h = h ^ (h >> 16);
         return h;
      endfunction

      function void clear_string();
         running_hash = seed;
         tail_bytes = '0;
         tail_count = '0;
         byte_count = '0;
         in_string = 1'b0;
      endfunction

      function void set_seed(bit [WORD_W-1:0] value);
         seed = value;
         if (!in_string) running_hash = seed;
      endfunction

      function void note_request(bit [BYTE_W-1:0] data_byte, bit last, bit empty_req);
         bit [WORD_W-1:0] h;
         if (!empty_req) begin
            if (!in_string) begin
               clear_string();
               in_string = 1'b1;
            end
            if (tail_count == 2'd3) begin
               running_hash = mix_word(running_hash, {data_byte, tail_bytes});
               tail_bytes = '0;
               tail_count = '0;
            end else begin
               tail_bytes[8*tail_count +: 8] = data_byte;
               tail_count = tail_count + 2'd1;
            end
            byte_count = byte_count + 32'd1;
         end
         if (last) begin
            if (in_string) begin
               h = running_hash;
               if (tail_count != 2'd0) h = mix_word(h, {8'h00, tail_bytes});
               h = h ^ byte_count;
            end else begin
               h = seed;
            end
            h = avalanche(h) & FOLD;
            expected_hashes.push_back(h[HASH_W-1:0]);
            clear_string();
         end
      endfunction

      function void check_response(bit [HASH_W-1:0] actual);
         bit [HASH_W-1:0] wanted;
         if (expected_hashes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response with no hash awaited: actual %h", actual);
         end else begin
            wanted = expected_hashes.pop_front();
            if (wanted !== actual) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("hash mismatch: expected %h actual %h", wanted, actual);
            end
         end
      endfunction

      function int outstanding();
         return expected_hashes.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [WORD_W-1:0] csr_wr_data;

   msh_req_if req_ch();
   msh_rsp_if rsp_ch();

   murmur_string_hash_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   string_hash_model hasher = new();

   // percent chance per cycle that each side sits idle
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // requests that carry a byte or end a string
   int counted_requests = 0;

   always #10 clock = ~clock;

   // one request: optional idle gap, then hold it until the block takes it
   task automatic send_request(input logic [BYTE_W-1:0] data_byte, input logic last,
                               input logic empty_req);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data_byte;
      req_ch.last      <= last;
      req_ch.empty_req <= empty_req;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      hasher.note_request(data_byte, last, empty_req);
      if (last || !empty_req) counted_requests++;
   endtask

   // stop sending and wait until every awaited hash is back, then let the mixer settle
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (hasher.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // seed writes happen only with the block idle
   task automatic write_seed(input logic [WORD_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      hasher.set_seed(value);
      csr_wr_en   <= 1'b0;
   endtask

   // well-formed strings with random content; a few stray empty requests mixed in
   task automatic send_random_strings(input int target);
      int start_count;
      int len;
      bit end_on_byte;
      start_count = counted_requests;
      while (counted_requests - start_count < target) begin
         // mostly short strings so every tail length comes up often
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         end_on_byte = (len != 0) && ($urandom_range(0, 4) != 0);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_request(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_request(BYTE_W'($urandom_range(0, 255)),
                         end_on_byte && (i == len - 1), 1'b0);
         end
         // empty request closes the string, or forms the whole zero-length string
         if (!end_on_byte)
            send_request(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
   endtask

   // response side: check on handshake, then pick next cycle's ready at random
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            hasher.check_response(rsp_ch.hash);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // main sequence
   initial begin
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last      <= 1'b0;
      req_ch.empty_req <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first phase: sender idles lightly, receiver stalls often
      send_idle_pct = 15;
      recv_idle_pct = 58;

      // directed part, seed still at its reset value of zero
      // zero-length string; data byte must be ignored
      send_request(8'ha5, 1'b1, 1'b1);
      // one, two, three and four byte strings cover every tail length
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h01, 1'b0, 1'b0);
      send_request(8'h80, 1'b0, 1'b0);
      send_request(8'h7f, 1'b1, 1'b0);
      repeat (3) send_request(8'hff, 1'b0, 1'b0);
      send_request(8'hff, 1'b1, 1'b0);
      // five bytes with an empty request in the middle that changes nothing
      send_request(8'h12, 1'b0, 1'b0);
      send_request(8'h33, 1'b0, 1'b1);
      send_request(8'h34, 1'b0, 1'b0);
      send_request(8'h56, 1'b0, 1'b0);
      send_request(8'h78, 1'b0, 1'b0);
      send_request(8'h9a, 1'b1, 1'b0);
      // empty request outside any string
      send_request(8'hff, 1'b0, 1'b1);
      // bytes then an empty request that ends the string
      send_request(8'hde, 1'b0, 1'b0);
      send_request(8'had, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b1);
      // zero-length string straight after a finished one
      send_request(8'h00, 1'b1, 1'b1);

      drain_responses();
      write_seed(32'hffff_ffff);
      send_random_strings(90);
      // sender holds off until everything awaited is back
      drain_responses();
      write_seed($urandom());
      send_random_strings(90);

      // second phase: roles swapped
      drain_responses();
      send_idle_pct = 58;
      recv_idle_pct = 15;
      write_seed(32'h8000_0001);
      send_random_strings(180);

      // third phase: no idling on either side, seed back to zero by a write
      drain_responses();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_seed(32'h0000_0000);
      send_random_strings(180);

      drain_responses();
      if (hasher.mismatch_count == 0 && hasher.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog against a hung handshake
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
design/msh_pkg.sv
design/msh_req_if.sv
design/msh_rsp_if.sv
design/msh_front.sv
design/msh_queue.sv
design/msh_back.sv
design/murmur_string_hash_top.sv
tb/tb_top.sv
